/* hdl/bsd_pkg.sv */
package bsd_pkg;

    // framing bytes
    localparam logic [7:0] MARK_START = 8'h7F;
    localparam logic [7:0] MARK_END   = 8'h7E;
    localparam logic [7:0] MARK_ESC   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;

    // field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 13;
    localparam int unsigned KIND_W = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVER  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd3;

    // receive state
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_FRAME = 3'b010,
        MODE_ESC   = 3'b100
    } mode_t;

    // one result word
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
    } result_t;

    // result of one input byte
    typedef struct packed {
        logic    valid;
        result_t res;
    } step_t;

endpackage

/* hdl/bsd_core.sv */
module bsd_core #(
    parameter int unsigned MAX_FRAME_BYTES = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_fire,
    input  logic [bsd_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [bsd_pkg::POS_W-1:0]   max_payload,
    output bsd_pkg::step_t              step
);

    localparam logic [16:0] MAX_W = 17'(MAX_FRAME_BYTES);

    bsd_pkg::mode_t              mode_reg, mode_next;
    logic [bsd_pkg::POS_W-1:0]   count_reg, count_next;
    logic                        over_reg, over_next;
    logic [bsd_pkg::POS_W-1:0]   cap;
    logic [bsd_pkg::BYTE_W-1:0]  pay_byte;
    logic                        has_room;

    // effective capacity
    assign cap = ({4'b0000, max_payload} > MAX_W) ? MAX_W[bsd_pkg::POS_W-1:0] : max_payload;
    assign has_room = count_reg < cap;

    // unescape when an escape is pending
    assign pay_byte = (mode_reg == bsd_pkg::MODE_ESC) ? (rx_byte ^ bsd_pkg::ESC_XOR) : rx_byte;

    // decode of one byte
    always_comb begin
        mode_next           = mode_reg;
        count_next          = count_reg;
        over_next           = over_reg;
        step.valid          = 1'b0;
        step.res.kind       = bsd_pkg::KIND_DATA;
        step.res.data_byte  = '0;
        step.res.position   = count_reg;
        if (rx_byte == bsd_pkg::MARK_START) begin
            step.valid    = (mode_reg == bsd_pkg::MODE_FRAME) || (mode_reg == bsd_pkg::MODE_ESC);
            step.res.kind = bsd_pkg::KIND_ABORT;
            mode_next     = bsd_pkg::MODE_FRAME;
            count_next    = '0;
            over_next     = 1'b0;
        end else begin
            case (mode_reg)
                bsd_pkg::MODE_FRAME: begin
                    if (rx_byte == bsd_pkg::MARK_END) begin
                        step.valid    = 1'b1;
                        step.res.kind = over_reg ? bsd_pkg::KIND_OVER : bsd_pkg::KIND_GOOD;
                        mode_next     = bsd_pkg::MODE_IDLE;
                        count_next    = '0;
                        over_next     = 1'b0;
                    end else if (rx_byte == bsd_pkg::MARK_ESC) begin
                        mode_next = bsd_pkg::MODE_ESC;
                    end else if (has_room) begin
                        step.valid         = 1'b1;
                        step.res.data_byte = pay_byte;
                        count_next         = count_reg + 1'b1;
                    end else begin
                        over_next = 1'b1;
                    end
                end
                bsd_pkg::MODE_ESC: begin
                    mode_next = bsd_pkg::MODE_FRAME;
                    if (has_room) begin
                        step.valid         = 1'b1;
                        step.res.data_byte = pay_byte;
                        count_next         = count_reg + 1'b1;
                    end else begin
                        over_next = 1'b1;
                    end
                end
                default: begin
                    // outside a frame: ignore the byte
                end
            endcase
        end
    end

    // state update on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= bsd_pkg::MODE_IDLE;
            count_reg <= '0;
            over_reg  <= 1'b0;
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            over_reg  <= over_next;
        end
    end

endmodule

/* hdl/byte_stuffing_deframer.sv */
// Receive deframer for a byte-stuffed serial link.
// Input channel s_*: one raw byte per word (s_rx_byte). A frame opens with
// 0x7F and closes with 0x7E; 0x7D escapes the next byte (restored by XOR 0x20).
// Output channel m_*: zero or one word per input byte. kind 0 carries a
// payload byte and its index, kind 1/2 report the frame length at the end
// (good/overflowed), kind 3 reports an abort by a new start marker.
// Config channel cfg_*: writes max_payload (receive capacity), always ready;
// write only while the block is idle.
// Results are registered in the output buffer before they appear on m_*.
// One byte per cycle while s_ready is high, set by the combinational bsd_core.
// A two-entry output buffer (output register plus skid register) keeps
// s_ready high while one result waits; s_ready drops only when both are full.
// Reset: synchronous active-low aresetn empties the buffer, returns to the
// idle state outside any frame and sets max_payload to 4096.
module byte_stuffing_deframer #(
    parameter int unsigned MAX_FRAME_BYTES = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bsd_pkg::BYTE_W-1:0]        s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bsd_pkg::KIND_W-1:0]        m_kind,
    output logic [bsd_pkg::BYTE_W-1:0]        m_data_byte,
    output logic [bsd_pkg::POS_W-1:0]         m_position,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsd_pkg::POS_W-1:0]         cfg_data
);

    logic [bsd_pkg::POS_W-1:0] max_payload_reg;
    logic                      in_fire;
    bsd_pkg::step_t            step;
    logic                      out_valid_reg, skid_valid_reg;
    bsd_pkg::result_t          out_reg, skid_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign in_fire   = s_valid && s_ready;

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= 13'd4096;
        end else if (cfg_valid) begin
            max_payload_reg <= cfg_data;
        end
    end

    bsd_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .rx_byte     (s_rx_byte),
        .max_payload (max_payload_reg),
        .step        (step)
    );

    // output register plus skid word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= in_fire && step.valid;
                end
            end else if (in_fire && step.valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload moves without reset
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else begin
                out_reg <= step.res;
            end
        end else if (in_fire && step.valid) begin
            skid_reg <= step.res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_kind      = out_reg.kind;
    assign m_data_byte = out_reg.data_byte;
    assign m_position  = out_reg.position;

endmodule
